// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int CMD_W      = 2;
    localparam int CAP_W      = 5;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 136;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 2'd0,
        CMD_PUT    = 2'd1,
        CMD_DELETE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_TOUCH,
        ACT_INSERT,
        ACT_REMOVE
    } t_act;

    typedef struct packed {
        t_act act;
        logic evict;
    } t_ctl;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

// ===== rtl/lkvc_cell.sv =====
module lkvc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_match_en,
    input  logic [lkvc_pkg::KEY_W-1:0] i_key,
    input  lkvc_pkg::t_ctl             i_ctl,
    input  lkvc_pkg::t_entry           i_prev,
    input  lkvc_pkg::t_entry           i_next,
    input  logic                       i_above,
    input  logic                       i_upto,
    output lkvc_pkg::t_entry           o_entry,
    output logic                       o_match,
    output logic [lkvc_pkg::VAL_W-1:0] o_hit_value,
    output logic [lkvc_pkg::VAL_W-1:0] o_tail_value
);

    lkvc_pkg::t_entry r_entry;
    lkvc_pkg::t_entry n_entry;
    logic             r_match;
    logic             n_match;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.act)
            lkvc_pkg::ACT_TOUCH: begin
                if (i_above) begin
                    n_entry = i_prev;
                end
            end
            lkvc_pkg::ACT_INSERT: begin
                // on eviction the first empty cell stays empty
                if (i_prev.valid && !(i_ctl.evict && !r_entry.valid)) begin
                    n_entry = i_prev;
                end
            end
            lkvc_pkg::ACT_REMOVE: begin
                if (i_upto) begin
                    n_entry = i_next;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    assign n_match = i_match_en ? (r_entry.valid && (r_entry.key == i_key)) : r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_match <= 1'b0;
        end else begin
            r_entry <= n_entry;
            r_match <= n_match;
        end
    end

    assign o_entry      = r_entry;
    assign o_match      = r_match;
    assign o_hit_value  = r_match ? r_entry.value : '0;
    assign o_tail_value = (r_entry.valid && !i_next.valid) ? r_entry.value : '0;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement, built as a row of
// ENTRIES cells kept in recency order: cell 0 holds the most recent entry and the valid
// entries always fill cells 0 to occupancy-1. In the cycle an operation transfers, every cell
// compares its key and registers a match bit. Then each cell loads from its neighbor (toward the
// tail on a touch or insert, toward the head on a delete) and the result goes to the output
// register. The next operation transfers as soon as the update is done, also while the previous
// result is still waiting; an update waits while the output register is full and m_tready is
// low. Capacity writes on the cfg channel are always accepted; a
// capacity of 0 acts as 1 and one above ENTRIES acts as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // command[1:0], key[65:2], new_value[129:66], zero fill
    input  logic [lkvc_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit[0], read_value[64:1], released_valid[65], released_value[129:66], zero fill
    output logic [lkvc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]          i_cfg_data
);

    localparam int OW = $clog2(ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_WORK
    } t_state;

    t_state                       r_state;
    logic [lkvc_pkg::CAP_W-1:0]   r_cap;
    logic [OW-1:0]                r_occ;
    logic [OW-1:0]                n_occ;
    logic [OW-1:0]                w_eff_cap;
    lkvc_pkg::t_cmd               r_cmd;
    logic [lkvc_pkg::KEY_W-1:0]   r_key;
    logic [lkvc_pkg::VAL_W-1:0]   r_value;

    logic                         r_out_valid;
    logic                         r_out_hit;
    logic [lkvc_pkg::VAL_W-1:0]   r_out_read;
    logic                         r_out_rel_valid;
    logic [lkvc_pkg::VAL_W-1:0]   r_out_rel_value;
    logic                         n_out_hit;
    logic [lkvc_pkg::VAL_W-1:0]   n_out_read;
    logic                         n_out_rel_valid;
    logic [lkvc_pkg::VAL_W-1:0]   n_out_rel_value;

    logic                         w_accept;
    logic                         w_fire;
    logic                         w_hit;
    logic                         w_evict;
    lkvc_pkg::t_ctl               w_ctl;
    logic [ENTRIES-1:0]           w_match;
    logic [ENTRIES-1:0]           w_above;
    logic [ENTRIES-1:0]           w_upto;
    logic [lkvc_pkg::VAL_W-1:0]   w_hit_value;
    logic [lkvc_pkg::VAL_W-1:0]   w_tail_value;
    logic [lkvc_pkg::VAL_W-1:0]   w_cell_hit [ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0]   w_cell_tail [ENTRIES];
    lkvc_pkg::t_entry             w_chain [ENTRIES+2];

    assign s_tready    = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = s_tvalid && s_tready;
    assign w_fire      = (r_state == S_WORK) && (!r_out_valid || m_tready);

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = OW'(1);
        end else if (int'(r_cap) > ENTRIES) begin
            w_eff_cap = OW'(ENTRIES);
        end else begin
            w_eff_cap = OW'(r_cap);
        end
    end

    assign w_hit   = |w_match;
    assign w_evict = (r_occ >= w_eff_cap);

    always_comb begin
        w_hit_value  = '0;
        w_tail_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_value  = w_hit_value | w_cell_hit[i];
            w_tail_value = w_tail_value | w_cell_tail[i];
        end
    end

    always_comb begin
        w_ctl.act       = lkvc_pkg::ACT_HOLD;
        w_ctl.evict     = w_evict;
        n_occ           = r_occ;
        n_out_hit       = w_hit;
        n_out_read      = '0;
        n_out_rel_valid = 1'b0;
        n_out_rel_value = '0;
        case (r_cmd)
            lkvc_pkg::CMD_GET: begin
                if (w_hit) begin
                    w_ctl.act  = lkvc_pkg::ACT_TOUCH;
                    n_out_read = w_hit_value;
                end
            end
            lkvc_pkg::CMD_PUT: begin
                if (w_hit) begin
                    w_ctl.act       = lkvc_pkg::ACT_TOUCH;
                    n_out_rel_valid = 1'b1;
                    n_out_rel_value = w_hit_value;
                end else begin
                    w_ctl.act = lkvc_pkg::ACT_INSERT;
                    if (w_evict) begin
                        n_out_rel_valid = 1'b1;
                        n_out_rel_value = w_tail_value;
                    end else begin
                        n_occ = OW'(r_occ + 1'b1);
                    end
                end
            end
            lkvc_pkg::CMD_DELETE: begin
                if (w_hit) begin
                    w_ctl.act       = lkvc_pkg::ACT_REMOVE;
                    n_out_rel_valid = 1'b1;
                    n_out_rel_value = w_hit_value;
                    n_occ           = OW'(r_occ - 1'b1);
                end
            end
            default: begin
                n_out_hit = 1'b0;
            end
        endcase
        if (!w_fire) begin
            w_ctl.act = lkvc_pkg::ACT_HOLD;
        end
    end

    // head of the row: the entry that becomes most recent
    assign w_chain[0].valid   = 1'b1;
    assign w_chain[0].key     = r_key;
    assign w_chain[0].value   = (r_cmd == lkvc_pkg::CMD_PUT) ? r_value : w_hit_value;
    assign w_chain[ENTRIES+1] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        localparam logic [ENTRIES-1:0] ABOVE_MASK = {ENTRIES{1'b1}} << g;
        localparam logic [ENTRIES-1:0] UPTO_MASK  = {ENTRIES{1'b1}} >> (ENTRIES - 1 - g);

        assign w_above[g] = |(w_match & ABOVE_MASK);
        assign w_upto[g]  = |(w_match & UPTO_MASK);

        lkvc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_match_en   (w_accept),
            .i_key        (s_tdata[65:2]),
            .i_ctl        (w_ctl),
            .i_prev       (w_chain[g]),
            .i_next       (w_chain[g+2]),
            .i_above      (w_above[g]),
            .i_upto       (w_upto[g]),
            .o_entry      (w_chain[g+1]),
            .o_match      (w_match[g]),
            .o_hit_value  (w_cell_hit[g]),
            .o_tail_value (w_cell_tail[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= lkvc_pkg::CAP_RESET;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_WORK;
                    end
                end
                S_WORK: begin
                    if (w_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_fire) begin
                r_occ           <= n_occ;
                r_out_valid     <= 1'b1;
                r_out_hit       <= n_out_hit;
                r_out_read      <= n_out_read;
                r_out_rel_valid <= n_out_rel_valid;
                r_out_rel_value <= n_out_rel_value;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= lkvc_pkg::t_cmd'(s_tdata[1:0]);
            r_key   <= s_tdata[65:2];
            r_value <= s_tdata[129:66];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out_rel_value, r_out_rel_valid, r_out_read, r_out_hit};

endmodule
